/* rtl/mbma_pkg.sv */
`timescale 1ns / 1ps

package mbma_pkg;

   localparam int PORTS     = 4;
   localparam int MAX_SYSEX = 4096;

   localparam int PORT_W     = 2;
   localparam int PORT_IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int COUNT_W    = $clog2(MAX_SYSEX + 1);

   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ONE,
      MODE_TWO_A,
      MODE_TWO_B
   } mode_type;

   typedef enum logic [1:0] {
      KIND_SHORT,
      KIND_SYSEX,
      KIND_OVERFLOW,
      KIND_NOTE_REPLY
   } kind_type;

   typedef enum logic {
      CMD_PUT_BYTE,
      CMD_NOTE_READ
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic [PORT_W-1:0] out_port;
      kind_type          kind;
      logic [23:0]       msg_bytes;
      logic [1:0]        msg_length;
      logic              last;
      logic              note_on;
   } result_type;

   // Mode that a byte taken in the idle mode leads to.
   function automatic mode_type status_mode(input logic [7:0] b);
      mode_type m;
      m = MODE_IDLE;
      case (b[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: m = MODE_TWO_A;
         4'hC, 4'hD:                   m = MODE_ONE;
         4'hF: begin
            if (b[3:0] == 4'h2) begin
               m = MODE_TWO_A;
            end else if (b[3:0] == 4'h1 || b[3:0] == 4'h3) begin
               m = MODE_ONE;
            end
         end
         default: m = MODE_IDLE;
      endcase
      return m;
   endfunction

endpackage

/* rtl/mbma_framer.sv */
`timescale 1ns / 1ps

module mbma_framer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  mbma_pkg::cmd_type           cmd,
   input  logic [mbma_pkg::PORT_W-1:0] port,
   input  logic [7:0]                  byte_in,
   output mbma_pkg::result_type        result
);

   mbma_pkg::mode_type                 mode_ff    [mbma_pkg::PORTS];
   mbma_pkg::mode_type                 mode_in    [mbma_pkg::PORTS];
   logic                               sysex_ff   [mbma_pkg::PORTS];
   logic                               sysex_in   [mbma_pkg::PORTS];
   logic [mbma_pkg::COUNT_W-1:0]       count_ff   [mbma_pkg::PORTS];
   logic [mbma_pkg::COUNT_W-1:0]       count_in   [mbma_pkg::PORTS];
   logic [15:0]                        partial_ff [mbma_pkg::PORTS];
   logic [15:0]                        partial_in [mbma_pkg::PORTS];
   logic                               note_ff;
   logic                               note_in;

   logic [mbma_pkg::PORT_IDX_W-1:0]    idx;
   logic                               port_ok;
   logic                               sysex_path;
   logic                               overflow;
   mbma_pkg::mode_type                 cur_mode;
   mbma_pkg::mode_type                 new_mode;

   assign idx        = port[mbma_pkg::PORT_IDX_W-1:0];
   assign port_ok    = 32'(port) < mbma_pkg::PORTS;
   assign sysex_path = sysex_ff[idx] || (byte_in == mbma_pkg::SYSEX_START);
   assign overflow   = count_ff[idx] >= mbma_pkg::COUNT_W'(mbma_pkg::MAX_SYSEX);
   assign cur_mode   = mode_ff[idx];
   assign new_mode   = mbma_pkg::status_mode(byte_in);

   always_comb begin
      mode_in    = mode_ff;
      sysex_in   = sysex_ff;
      count_in   = count_ff;
      partial_in = partial_ff;
      note_in    = note_ff;
      if (accept) begin
         if (cmd == mbma_pkg::CMD_NOTE_READ) begin
            note_in = 1'b0;
         end else if (port_ok) begin
            if (sysex_path) begin
               if (byte_in == mbma_pkg::SYSEX_END) begin
                  sysex_in[idx] = 1'b0;
                  count_in[idx] = '0;
               end else begin
                  sysex_in[idx] = 1'b1;
                  if (!overflow) begin
                     count_in[idx] = count_ff[idx] + 1'b1;
                  end
               end
            end else begin
               unique case (cur_mode)
                  mbma_pkg::MODE_IDLE: begin
                     mode_in[idx]    = new_mode;
                     partial_in[idx] = {8'h00, byte_in};
                     if (byte_in[7:4] == 4'h9) begin
                        note_in = 1'b1;
                     end
                  end
                  mbma_pkg::MODE_ONE: mode_in[idx] = mbma_pkg::MODE_IDLE;
                  mbma_pkg::MODE_TWO_A: begin
                     mode_in[idx]    = mbma_pkg::MODE_TWO_B;
                     partial_in[idx] = {byte_in, partial_ff[idx][7:0]};
                  end
                  mbma_pkg::MODE_TWO_B: mode_in[idx] = mbma_pkg::MODE_IDLE;
                  default: mode_in[idx] = mbma_pkg::MODE_IDLE;
               endcase
            end
         end
      end
   end

   always_comb begin
      result          = '0;
      result.out_port = port;
      result.kind     = mbma_pkg::KIND_SHORT;
      if (accept) begin
         if (cmd == mbma_pkg::CMD_NOTE_READ) begin
            result.valid   = 1'b1;
            result.kind    = mbma_pkg::KIND_NOTE_REPLY;
            result.note_on = note_ff;
         end else if (port_ok) begin
            if (sysex_path) begin
               result.valid     = 1'b1;
               result.msg_bytes = {16'h0000, byte_in};
               if (byte_in == mbma_pkg::SYSEX_END) begin
                  result.kind       = mbma_pkg::KIND_SYSEX;
                  result.msg_length = 2'd1;
                  result.last       = 1'b1;
               end else if (overflow) begin
                  result.kind = mbma_pkg::KIND_OVERFLOW;
               end else begin
                  result.kind       = mbma_pkg::KIND_SYSEX;
                  result.msg_length = 2'd1;
               end
            end else begin
               unique case (cur_mode)
                  mbma_pkg::MODE_IDLE: begin
                     if (new_mode == mbma_pkg::MODE_IDLE) begin
                        result.valid      = 1'b1;
                        result.msg_bytes  = {16'h0000, byte_in};
                        result.msg_length = 2'd1;
                     end
                  end
                  mbma_pkg::MODE_ONE: begin
                     result.valid      = 1'b1;
                     result.msg_bytes  = {8'h00, byte_in, partial_ff[idx][7:0]};
                     result.msg_length = 2'd2;
                  end
                  mbma_pkg::MODE_TWO_A: result.valid = 1'b0;
                  mbma_pkg::MODE_TWO_B: begin
                     result.valid      = 1'b1;
                     result.msg_bytes  = {byte_in, partial_ff[idx]};
                     result.msg_length = 2'd3;
                  end
                  default: result.valid = 1'b0;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      partial_ff <= partial_in;
      if (reset) begin
         for (int i = 0; i < mbma_pkg::PORTS; i++) begin
            mode_ff[i]  <= mbma_pkg::MODE_IDLE;
            sysex_ff[i] <= 1'b0;
            count_ff[i] <= '0;
         end
         note_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         sysex_ff <= sysex_in;
         count_ff <= count_in;
         note_ff  <= note_in;
      end
   end

`ifndef SYNTH
   a_note_cleared: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == mbma_pkg::CMD_NOTE_READ |=> !note_ff)
      else $error("Note-on flag not cleared after a read.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[idx] <= mbma_pkg::COUNT_W'(mbma_pkg::MAX_SYSEX))
      else $error("Sysex count ran past its limit.");

   a_overflow_no_bytes: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.kind == mbma_pkg::KIND_OVERFLOW |-> result.msg_length == 2'd0)
      else $error("Overflow result claims valid bytes.");
`endif

endmodule

/* rtl/midi_byte_message_assembler.sv */
`timescale 1ns / 1ps

// Frames MIDI bytes for several output ports into messages, one word per
// cycle with no running status. Each accepted word is handled in the cycle it
// arrives against per-port state, and its result, if any, lands in an output
// register backed by a one-word skid stage, so the input keeps taking a word
// every cycle while the result side is free and stalls only once both are
// full. Short messages come out packed with their length, sysex bytes come
// out one at a time with tlast on the closing F7, and bytes past the sysex
// limit come out as drop notices. A note-on read word returns and clears the
// sticky note-on flag.
module midi_byte_message_assembler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // port [1:0], byte_in [9:2], zero [15:10]
   input  logic        req_tuser,  // cmd [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // out_port [1:0], msg_bytes [25:2],
                                   // msg_length [27:26], note_on [28], zero [31:29]
   output logic [1:0]  rsp_tuser,  // kind [1:0]
   output logic        rsp_tlast   // last
);

   logic                 req_accept;
   logic                 rsp_pop;
   mbma_pkg::result_type result;
   mbma_pkg::result_type out_ff;
   mbma_pkg::result_type out_in;
   mbma_pkg::result_type skid_ff;
   mbma_pkg::result_type skid_in;
   logic                 out_vld_ff;
   logic                 out_vld_in;
   logic                 skid_vld_ff;
   logic                 skid_vld_in;
   logic                 push;

   assign req_tready = !skid_vld_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = out_vld_ff && rsp_tready;
   assign push       = result.valid;

   mbma_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .cmd     (mbma_pkg::cmd_type'(req_tuser)),
      .port    (req_tdata[1:0]),
      .byte_in (req_tdata[9:2]),
      .result  (result)
   );

   always_comb begin
      out_in      = out_ff;
      skid_in     = skid_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (rsp_pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!out_vld_ff || rsp_pop) begin
            out_in     = result;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = result;
            skid_vld_in = 1'b1;
         end
      end else if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, out_ff.note_on, out_ff.msg_length, out_ff.msg_bytes,
                        out_ff.out_port};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("Skid stage holds a word while the output register is empty.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |=> out_vld_ff)
      else $error("Output word lost while stalled.");

   a_overflow_to_skid: assert property (@(posedge clock) disable iff (reset)
      push && out_vld_ff && !rsp_tready && !skid_vld_ff |=> skid_vld_ff)
      else $error("Result dropped while the output register was stalled.");
`endif

endmodule

/* bench/midi_byte_message_assembler_tb.sv */
`timescale 1ns / 1ps

module midi_byte_message_assembler_tb;

   localparam logic [7:0] MTC_QUARTER = 8'hF1;
   localparam logic [7:0] SONG_POS    = 8'hF2;
   localparam logic [7:0] SONG_SEL    = 8'hF3;
   localparam logic [3:0] NOTE_ON_HI  = 4'h9;

   class frame_scoreboard;
      mbma_pkg::result_type         frames[$];
      mbma_pkg::mode_type           port_mode[mbma_pkg::PORTS];
      bit                           in_sysex[mbma_pkg::PORTS];
      logic [15:0]                  partial[mbma_pkg::PORTS];
      logic [mbma_pkg::COUNT_W-1:0] sysex_count[mbma_pkg::PORTS];
      bit                           note_seen;
      int                           errors;

      function new();
         for (int i = 0; i < mbma_pkg::PORTS; i++) begin
            port_mode[i]   = mbma_pkg::MODE_IDLE;
            in_sysex[i]    = 1'b0;
            partial[i]     = '0;
            sysex_count[i] = '0;
         end
         note_seen = 1'b0;
         errors    = 0;
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 20) begin
            $display("%0t mismatch: %s", $realtime, msg);
         end
      endtask

      // Works out the frame, if any, that an accepted input word leads to.
      function void note_word(input mbma_pkg::cmd_type c, input logic [1:0] p,
                              input logic [7:0] b);
         mbma_pkg::result_type r;
         mbma_pkg::mode_type   m;
         r          = '0;
         r.valid    = 1'b1;
         r.out_port = p;
         if (c == mbma_pkg::CMD_NOTE_READ) begin
            r.kind    = mbma_pkg::KIND_NOTE_REPLY;
            r.note_on = note_seen;
            note_seen = 1'b0;
            frames.push_back(r);
            return;
         end
         if (in_sysex[p] || b == mbma_pkg::SYSEX_START) begin
            in_sysex[p] = 1'b1;
            r.msg_bytes = {16'h0000, b};
            if (b == mbma_pkg::SYSEX_END) begin
               in_sysex[p]    = 1'b0;
               sysex_count[p] = '0;
               r.kind         = mbma_pkg::KIND_SYSEX;
               r.msg_length   = 2'd1;
               r.last         = 1'b1;
            end else if (sysex_count[p] >= mbma_pkg::MAX_SYSEX) begin
               r.kind = mbma_pkg::KIND_OVERFLOW;
            end else begin
               sysex_count[p] = sysex_count[p] + 1'b1;
               r.kind         = mbma_pkg::KIND_SYSEX;
               r.msg_length   = 2'd1;
            end
            frames.push_back(r);
            return;
         end
         r.kind = mbma_pkg::KIND_SHORT;
         case (port_mode[p])
            mbma_pkg::MODE_IDLE: begin
               if (b[7:4] == NOTE_ON_HI) begin
                  note_seen = 1'b1;
               end
               m = mbma_pkg::MODE_IDLE;
               if (b[7:4] inside {4'h8, 4'h9, 4'hA, 4'hB, 4'hE} || b == SONG_POS) begin
                  m = mbma_pkg::MODE_TWO_A;
               end else if (b[7:4] inside {4'hC, 4'hD} || b == MTC_QUARTER ||
                            b == SONG_SEL) begin
                  m = mbma_pkg::MODE_ONE;
               end
               partial[p]   = {8'h00, b};
               port_mode[p] = m;
               if (m == mbma_pkg::MODE_IDLE) begin
                  r.msg_bytes  = {16'h0000, b};
                  r.msg_length = 2'd1;
                  frames.push_back(r);
               end
            end
            mbma_pkg::MODE_ONE: begin
               port_mode[p] = mbma_pkg::MODE_IDLE;
               r.msg_bytes  = {8'h00, b, partial[p][7:0]};
               r.msg_length = 2'd2;
               frames.push_back(r);
            end
            mbma_pkg::MODE_TWO_A: begin
               partial[p][15:8] = b;
               port_mode[p]     = mbma_pkg::MODE_TWO_B;
            end
            default: begin
               port_mode[p] = mbma_pkg::MODE_IDLE;
               r.msg_bytes  = {b, partial[p]};
               r.msg_length = 2'd3;
               frames.push_back(r);
            end
         endcase
      endfunction

      task check_frame(input mbma_pkg::result_type got);
         mbma_pkg::result_type want;
         if (frames.size() == 0) begin
            report($sformatf("unexpected word %h", got));
            return;
         end
         want = frames.pop_front();
         if (got.out_port !== want.out_port || got.kind !== want.kind ||
             got.msg_bytes !== want.msg_bytes || got.msg_length !== want.msg_length ||
             got.last !== want.last || got.note_on !== want.note_on) begin
            report($sformatf("port %h kind %h bytes %h len %h last %b note %b, want %h %h %h %h %b %b",
                             got.out_port, got.kind, got.msg_bytes, got.msg_length, got.last,
                             got.note_on, want.out_port, want.kind, want.msg_bytes,
                             want.msg_length, want.last, want.note_on));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   frame_scoreboard board = new();
   bit src_idle = 1'b1;
   bit snk_idle = 1'b1;
   bit hold_off_req = 1'b0;
   int words_sent = 0;

   midi_byte_message_assembler uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #10 clock = ~clock;

   task automatic send_word(input mbma_pkg::cmd_type c, input logic [1:0] p,
                            input logic [7:0] b);
      if (src_idle && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b000000, b, p};
      req_tuser  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_word(c, p, b);
      words_sent++;
   endtask

   task automatic put(input logic [1:0] p, input logic [7:0] b);
      send_word(mbma_pkg::CMD_PUT_BYTE, p, b);
   endtask

   task automatic read_flag(input logic [1:0] p);
      send_word(mbma_pkg::CMD_NOTE_READ, p, 8'($urandom_range(0, 255)));
   endtask

   function automatic logic [7:0] data_byte();
      return 8'($urandom_range(0, 127));
   endfunction

   // Mostly well-formed messages with random content, plus broken runs and noise.
   task automatic random_sequence();
      logic [1:0] p;
      logic [7:0] b;
      int         pick;
      p    = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         case ($urandom_range(0, 5))
            0: b = 8'h80;
            1: b = 8'h90;
            2: b = 8'hA0;
            3: b = 8'hB0;
            4: b = 8'hE0;
            default: b = SONG_POS;
         endcase
         if (b != SONG_POS) begin
            b[3:0] = 4'($urandom_range(0, 15));
         end
         put(p, b);
         put(p, data_byte());
         put(p, data_byte());
      end else if (pick < 45) begin
         case ($urandom_range(0, 3))
            0: b = {4'hC, 4'($urandom_range(0, 15))};
            1: b = {4'hD, 4'($urandom_range(0, 15))};
            2: b = MTC_QUARTER;
            default: b = SONG_SEL;
         endcase
         put(p, b);
         put(p, data_byte());
      end else if (pick < 55) begin
         b = ($urandom_range(0, 1) == 0) ? data_byte() : 8'($urandom_range(8'hF4, 8'hFF));
         if (b == mbma_pkg::SYSEX_END) begin
            b = 8'hF8;
         end
         put(p, b);
      end else if (pick < 68) begin
         put(p, mbma_pkg::SYSEX_START);
         repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            put(p, (b == mbma_pkg::SYSEX_END) ? data_byte() : b);
         end
         put(p, mbma_pkg::SYSEX_END);
      end else if (pick < 78) begin
         read_flag(p);
      end else if (pick < 88) begin
         put(p, {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))});
         put(p, data_byte());
         if ($urandom_range(0, 1) == 0) begin
            put(p, mbma_pkg::SYSEX_START);
            put(p, data_byte());
         end
      end else begin
         put(p, 8'($urandom_range(0, 255)));
      end
   endtask

   always @(posedge clock) begin
      mbma_pkg::result_type got;
      int                   stall_left;
      if (rsp_tvalid && rsp_tready) begin
         got            = '0;
         got.valid      = 1'b1;
         got.out_port   = rsp_tdata[1:0];
         got.kind       = mbma_pkg::kind_type'(rsp_tuser);
         got.msg_bytes  = rsp_tdata[25:2];
         got.msg_length = rsp_tdata[27:26];
         got.last       = rsp_tlast;
         got.note_on    = rsp_tdata[28];
         board.check_frame(got);
      end
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         stall_left   = 300;
      end else if (stall_left == 0 && snk_idle && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 8);
      end
      rsp_tready <= (stall_left == 0) && !reset;
      if (stall_left > 0) begin
         stall_left--;
      end
   end

   initial begin
      #10_000_000;
      $display("[midi_byte_message_assembler] ERROR");
      $finish;
   end

   initial begin
      bit held_off;
      held_off = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The flag is clear after reset; a note-on sets it until the next read.
      read_flag(2'd3);
      put(2'd0, 8'h90);
      put(2'd0, 8'h3C);
      put(2'd0, 8'h7F);
      read_flag(2'd2);
      read_flag(2'd1);
      put(2'd1, 8'hC5);
      put(2'd1, 8'h12);
      put(2'd2, SONG_POS);
      put(2'd2, 8'h00);
      put(2'd2, 8'h7F);
      put(2'd3, MTC_QUARTER);
      put(2'd3, 8'h55);
      put(2'd0, SONG_SEL);
      put(2'd0, 8'h7F);
      put(2'd1, 8'h00);
      put(2'd1, 8'hF6);
      put(2'd1, 8'hFF);
      // Status bytes that arrive while data is pending are taken as data.
      put(2'd2, 8'h80);
      put(2'd2, 8'h9A);
      put(2'd2, 8'hFE);
      read_flag(2'd0);
      // A pending short message resumes once the sysex run closes.
      put(2'd3, 8'hB0);
      put(2'd3, mbma_pkg::SYSEX_START);
      put(2'd3, 8'h90);
      put(2'd3, mbma_pkg::SYSEX_START);
      put(2'd3, mbma_pkg::SYSEX_END);
      put(2'd3, 8'h11);
      put(2'd3, 8'h22);
      read_flag(2'd0);

      words_sent = 0;
      while (words_sent < 340) begin
         if (!held_off && words_sent >= 100) begin
            hold_off_req = 1'b1;
            held_off     = 1'b1;
         end
         random_sequence();
      end
      src_idle = 1'b0;
      snk_idle = 1'b0;
      while (words_sent < 400) begin
         random_sequence();
      end
      req_tvalid <= 1'b0;

      while (board.frames.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.frames.size() != 0) begin
         board.report($sformatf("%0d words never arrived", board.frames.size()));
      end
      if (board.errors == 0) begin
         $display("[midi_byte_message_assembler] OK");
      end else begin
         $display("[midi_byte_message_assembler] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/mbma_pkg.sv
rtl/mbma_framer.sv
rtl/midi_byte_message_assembler.sv
bench/midi_byte_message_assembler_tb.sv
